// ===== hdl/obca_pkg.sv =====
// ----------------------------------------------------------------------------
// obca_pkg
// shared constants and helpers for the ohlcv bar cascade aggregator
// ----------------------------------------------------------------------------
package obca_pkg;

  localparam int RATIO_BITS     = 7;
  localparam int COUNT_BITS     = 6;
  localparam int CFG_INDEX_BITS = 3;
  localparam int TOTAL_BITS     = 63;
  localparam int BAR_VOL_EXTRA  = 6;
  localparam int MAX_RESULTS    = 4;
  localparam int TF_BITS        = 2;

  localparam logic [RATIO_BITS-1:0] RATIO_MAX = 7'd64;
  localparam logic [RATIO_BITS-1:0] RATIO_MIN = 7'd1;

  localparam logic [RATIO_BITS-1:0] RATIO_LEVEL1_RESET = 7'd6;
  localparam logic [RATIO_BITS-1:0] RATIO_LEVEL2_RESET = 7'd2;
  localparam logic [RATIO_BITS-1:0] RATIO_LEVEL3_RESET = 7'd5;
  localparam logic [RATIO_BITS-1:0] LOCAL_WINDOW_RESET = 7'd6;
  localparam logic [31:0]           INITIAL_LOW_RESET  = 32'd1000000;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_LEVEL1 = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_LEVEL2 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO_LEVEL3 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOCAL_WINDOW = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_LOW  = 3'd4;

  localparam logic [TF_BITS-1:0] TF_BASE   = 2'd0;
  localparam logic [TF_BITS-1:0] TF_LEVEL1 = 2'd1;
  localparam logic [TF_BITS-1:0] TF_LEVEL2 = 2'd2;
  localparam logic [TF_BITS-1:0] TF_LEVEL3 = 2'd3;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [RATIO_BITS-1:0] eff_ratio(input logic [RATIO_BITS-1:0] r);
    logic [RATIO_BITS-1:0] e;
    if (r == '0) begin
      e = RATIO_MIN;
    end else if (r > RATIO_MAX) begin
      e = RATIO_MAX;
    end else begin
      e = r;
    end
    return e;
  endfunction

  function automatic logic count_reaches(input logic [COUNT_BITS-1:0] cnt,
                                         input logic [RATIO_BITS-1:0] r);
    logic [RATIO_BITS-1:0] nxt;
    nxt = RATIO_BITS'(cnt) + RATIO_BITS'(1);
    return nxt >= eff_ratio(r);
  endfunction

endpackage

// ===== hdl/obca_cfg_if.sv =====
// ----------------------------------------------------------------------------
// obca_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
interface obca_cfg_if import obca_pkg::*; #(
  parameter int DATA_BITS = 24
);
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [DATA_BITS-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/obca_candle_if.sv =====
// ----------------------------------------------------------------------------
// obca_candle_if
// base candle input channel
// ----------------------------------------------------------------------------
interface obca_candle_if #(
  parameter int PRICE_BITS  = 24,
  parameter int VOLUME_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [PRICE_BITS-1:0]  open_price;
  logic [PRICE_BITS-1:0]  high_price;
  logic [PRICE_BITS-1:0]  low_price;
  logic [PRICE_BITS-1:0]  close_price;
  logic [VOLUME_BITS-1:0] trade_volume;

  modport source (output valid, output open_price, output high_price, output low_price,
                  output close_price, output trade_volume, input ready);
  modport sink   (input valid, input open_price, input high_price, input low_price,
                  input close_price, input trade_volume, output ready);
endinterface

// ===== hdl/obca_bar_if.sv =====
// ----------------------------------------------------------------------------
// obca_bar_if
// result channel: base candle and completed bars with running status
// ----------------------------------------------------------------------------
interface obca_bar_if import obca_pkg::*; #(
  parameter int PRICE_BITS  = 24,
  parameter int VOLUME_BITS = 32
);
  logic                                 valid;
  logic                                 ready;
  logic [TF_BITS-1:0]                   timeframe;
  logic [PRICE_BITS-1:0]                bar_open;
  logic [PRICE_BITS-1:0]                bar_high;
  logic [PRICE_BITS-1:0]                bar_low;
  logic [PRICE_BITS-1:0]                bar_close;
  logic [VOLUME_BITS+BAR_VOL_EXTRA-1:0] bar_volume;
  logic [PRICE_BITS-1:0]                day_high;
  logic [PRICE_BITS-1:0]                day_low;
  logic [PRICE_BITS-1:0]                window_high;
  logic [PRICE_BITS-1:0]                window_low;
  logic [TOTAL_BITS-1:0]                running_volume;
  logic                                 last_of_run;

  modport source (output valid, output timeframe, output bar_open, output bar_high,
                  output bar_low, output bar_close, output bar_volume, output day_high,
                  output day_low, output window_high, output window_low,
                  output running_volume, output last_of_run, input ready);
  modport sink   (input valid, input timeframe, input bar_open, input bar_high,
                  input bar_low, input bar_close, input bar_volume, input day_high,
                  input day_low, input window_high, input window_low,
                  input running_volume, input last_of_run, output ready);
endinterface

// ===== hdl/obca_level.sv =====
// ----------------------------------------------------------------------------
// obca_level
// one aggregation level: counts incoming bars and builds the open, high,
// low and saturating volume of the bar in progress
// ----------------------------------------------------------------------------
module obca_level import obca_pkg::*; #(
  parameter int PRICE_BITS = 24,
  parameter int VOL_BITS   = 38
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [RATIO_BITS-1:0] ratio,
  input  logic [PRICE_BITS-1:0] in_open,
  input  logic [PRICE_BITS-1:0] in_high,
  input  logic [PRICE_BITS-1:0] in_low,
  input  logic [VOL_BITS-1:0]   in_vol,
  output logic                  done,
  output logic [PRICE_BITS-1:0] out_open,
  output logic [PRICE_BITS-1:0] out_high,
  output logic [PRICE_BITS-1:0] out_low,
  output logic [VOL_BITS-1:0]   out_vol
);

  logic [COUNT_BITS-1:0] count;
  logic [PRICE_BITS-1:0] level_open;
  logic [PRICE_BITS-1:0] level_high;
  logic [PRICE_BITS-1:0] level_low;
  logic [VOL_BITS-1:0]   level_volume;
  logic [VOL_BITS:0]     vol_sum;
  logic                  first;

  assign first    = (count == '0);
  assign done     = count_reaches(count, ratio);
  assign out_open = first ? in_open : level_open;
  assign out_high = (in_high > level_high) ? in_high : level_high;
  assign out_low  = (in_low < level_low) ? in_low : level_low;
  assign vol_sum  = {1'b0, level_volume} + {1'b0, in_vol};
  assign out_vol  = vol_sum[VOL_BITS] ? {VOL_BITS{1'b1}} : vol_sum[VOL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (advance && first) begin
      level_open <= in_open;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      level_high   <= '0;
      level_low    <= '1;
      level_volume <= '0;
    end else if (advance) begin
      if (done) begin
        count        <= '0;
        level_high   <= '0;
        level_low    <= '1;
        level_volume <= '0;
      end else begin
        count        <= count + COUNT_BITS'(1);
        level_high   <= out_high;
        level_low    <= out_low;
        level_volume <= out_vol;
      end
    end
  end

endmodule

// ===== hdl/ohlcv_bar_cascade_aggregator.sv =====
// ----------------------------------------------------------------------------
// ohlcv_bar_cascade_aggregator
// rolls base ohlcv candles into three cascaded bar levels with daily,
// window and running volume status
// ----------------------------------------------------------------------------
// usage:
//   candle : base candle input, one transfer per candle
//   bar    : results, the base candle first, then each bar it completes,
//            last_of_run marks the final result of a candle
//   cfg    : register writes, always ready; the user must see that they are
//            taken only while the block is idle; the block does not enforce it
// a candle passes the input register and then the result buffer before its
// first result is valid; it produces n (1 to 4) results on the single result port
// a candle sits in the input register while the previous candle's results
// drain; all state is updated in the cycle it moves to the result buffer
// reset clears counters and bars, restores register defaults and sets
// daily, window and pending lows to the default initial low
// a stalled receiver holds the current result; one more candle is held in
// the input register, then candle.ready drops
// ----------------------------------------------------------------------------
module ohlcv_bar_cascade_aggregator import obca_pkg::*; #(
  parameter int PRICE_BITS  = 24,
  parameter int VOLUME_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  obca_cfg_if.sink      cfg,
  obca_candle_if.sink   candle,
  obca_bar_if.source    bar
);

  localparam int BARVOL_BITS = VOLUME_BITS + BAR_VOL_EXTRA;
  localparam int SLOT_BITS   = $clog2(MAX_RESULTS);
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  // configuration
  logic [RATIO_BITS-1:0] ratio_level1;
  logic [RATIO_BITS-1:0] ratio_level2;
  logic [RATIO_BITS-1:0] ratio_level3;
  logic [RATIO_BITS-1:0] local_window;
  logic [PRICE_BITS-1:0] initial_low;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_level1 <= RATIO_LEVEL1_RESET;
      ratio_level2 <= RATIO_LEVEL2_RESET;
      ratio_level3 <= RATIO_LEVEL3_RESET;
      local_window <= LOCAL_WINDOW_RESET;
      initial_low  <= PRICE_BITS'(INITIAL_LOW_RESET);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RATIO_LEVEL1: ratio_level1 <= cfg.data[RATIO_BITS-1:0];
        REG_RATIO_LEVEL2: ratio_level2 <= cfg.data[RATIO_BITS-1:0];
        REG_RATIO_LEVEL3: ratio_level3 <= cfg.data[RATIO_BITS-1:0];
        REG_LOCAL_WINDOW: local_window <= cfg.data[RATIO_BITS-1:0];
        REG_INITIAL_LOW:  initial_low  <= cfg.data[PRICE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  logic                   in_full;
  logic [PRICE_BITS-1:0]  in_open;
  logic [PRICE_BITS-1:0]  in_high;
  logic [PRICE_BITS-1:0]  in_low;
  logic [PRICE_BITS-1:0]  in_close;
  logic [VOLUME_BITS-1:0] in_vol;

  // result buffer
  logic                   out_full;
  logic [SLOT_BITS-1:0]   out_idx;
  logic [SLOT_BITS-1:0]   out_last;
  logic [PRICE_BITS-1:0]  slot_open [MAX_RESULTS];
  logic [PRICE_BITS-1:0]  slot_high [MAX_RESULTS];
  logic [PRICE_BITS-1:0]  slot_low  [MAX_RESULTS];
  logic [BARVOL_BITS-1:0] slot_vol  [MAX_RESULTS];
  logic [PRICE_BITS-1:0]  res_close;
  logic [PRICE_BITS-1:0]  res_day_high;
  logic [PRICE_BITS-1:0]  res_day_low;
  logic [PRICE_BITS-1:0]  win_high_old;
  logic [PRICE_BITS-1:0]  win_low_old;
  logic [PRICE_BITS-1:0]  win_high_new;
  logic [PRICE_BITS-1:0]  win_low_new;
  logic [TOTAL_BITS-1:0]  total_old;
  logic [TOTAL_BITS-1:0]  total_new;

  logic out_take;
  logic out_done;
  logic fire;

  assign out_take     = out_full && bar.ready;
  assign out_done     = out_take && (out_idx == out_last);
  assign fire         = in_full && (!out_full || out_done);
  assign candle.ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (candle.ready) begin
      in_full <= candle.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (candle.valid && candle.ready) begin
      in_open  <= candle.open_price;
      in_high  <= candle.high_price;
      in_low   <= candle.low_price;
      in_close <= candle.close_price;
      in_vol   <= candle.trade_volume;
    end
  end

  // running state
  logic [PRICE_BITS-1:0] day_high;
  logic [PRICE_BITS-1:0] day_low;
  logic [PRICE_BITS-1:0] local_high;
  logic [PRICE_BITS-1:0] local_low;
  logic [PRICE_BITS-1:0] pend_high;
  logic [PRICE_BITS-1:0] pend_low;
  logic [COUNT_BITS-1:0] count_window;
  logic [TOTAL_BITS-1:0] volume_total;

  logic [PRICE_BITS-1:0] day_high_next;
  logic [PRICE_BITS-1:0] day_low_next;
  logic [BARVOL_BITS-1:0] base_vol;

  assign day_high_next = (in_high > day_high) ? in_high : day_high;
  assign day_low_next  = (in_low < day_low) ? in_low : day_low;
  assign base_vol      = BARVOL_BITS'(in_vol);

  // level cascade
  logic                   done1, done2, done3;
  logic                   adv2, adv3, adv_win;
  logic [PRICE_BITS-1:0]  b1_open, b1_high, b1_low;
  logic [PRICE_BITS-1:0]  b2_open, b2_high, b2_low;
  logic [PRICE_BITS-1:0]  b3_open, b3_high, b3_low;
  logic [BARVOL_BITS-1:0] b1_vol, b2_vol, b3_vol;

  assign adv2    = fire && done1;
  assign adv3    = adv2 && done2;
  assign adv_win = adv3 && done3;

  obca_level #(.PRICE_BITS(PRICE_BITS), .VOL_BITS(BARVOL_BITS)) u_level1 (
    .clk      (clk),
    .rst      (rst),
    .advance  (fire),
    .ratio    (ratio_level1),
    .in_open  (in_open),
    .in_high  (in_high),
    .in_low   (in_low),
    .in_vol   (base_vol),
    .done     (done1),
    .out_open (b1_open),
    .out_high (b1_high),
    .out_low  (b1_low),
    .out_vol  (b1_vol)
  );

  obca_level #(.PRICE_BITS(PRICE_BITS), .VOL_BITS(BARVOL_BITS)) u_level2 (
    .clk      (clk),
    .rst      (rst),
    .advance  (adv2),
    .ratio    (ratio_level2),
    .in_open  (b1_open),
    .in_high  (b1_high),
    .in_low   (b1_low),
    .in_vol   (b1_vol),
    .done     (done2),
    .out_open (b2_open),
    .out_high (b2_high),
    .out_low  (b2_low),
    .out_vol  (b2_vol)
  );

  obca_level #(.PRICE_BITS(PRICE_BITS), .VOL_BITS(BARVOL_BITS)) u_level3 (
    .clk      (clk),
    .rst      (rst),
    .advance  (adv3),
    .ratio    (ratio_level3),
    .in_open  (b2_open),
    .in_high  (b2_high),
    .in_low   (b2_low),
    .in_vol   (b2_vol),
    .done     (done3),
    .out_open (b3_open),
    .out_high (b3_high),
    .out_low  (b3_low),
    .out_vol  (b3_vol)
  );

  // running volume over level-2 bars
  logic [TOTAL_BITS:0]   total_sum;
  logic [TOTAL_BITS-1:0] total_sat;

  assign total_sum = {1'b0, volume_total} + (TOTAL_BITS + 1)'(b2_vol);
  assign total_sat = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];

  // local window over level-3 bars
  logic [PRICE_BITS-1:0] pend_high_acc;
  logic [PRICE_BITS-1:0] pend_low_acc;
  logic                  win_latch;

  assign pend_high_acc = (b3_high > pend_high) ? b3_high : pend_high;
  assign pend_low_acc  = (b3_low < pend_low) ? b3_low : pend_low;
  assign win_latch     = count_reaches(count_window, local_window);

  always_ff @(posedge clk) begin
    if (rst) begin
      day_high     <= '0;
      day_low      <= PRICE_BITS'(INITIAL_LOW_RESET);
      local_high   <= '0;
      local_low    <= PRICE_BITS'(INITIAL_LOW_RESET);
      pend_high    <= '0;
      pend_low     <= PRICE_BITS'(INITIAL_LOW_RESET);
      count_window <= '0;
      volume_total <= '0;
    end else begin
      if (fire) begin
        day_high <= day_high_next;
        day_low  <= day_low_next;
      end
      if (adv3) begin
        volume_total <= total_sat;
      end
      if (adv_win) begin
        if (win_latch) begin
          local_high   <= pend_high_acc;
          local_low    <= pend_low_acc;
          pend_high    <= '0;
          pend_low     <= initial_low;
          count_window <= '0;
        end else begin
          pend_high    <= pend_high_acc;
          pend_low     <= pend_low_acc;
          count_window <= count_window + COUNT_BITS'(1);
        end
      end
    end
  end

  // result buffer control
  logic [SLOT_BITS-1:0] last_next;

  always_comb begin
    if (!done1) begin
      last_next = SLOT_BITS'(TF_BASE);
    end else if (!done2) begin
      last_next = SLOT_BITS'(TF_LEVEL1);
    end else if (!done3) begin
      last_next = SLOT_BITS'(TF_LEVEL2);
    end else begin
      last_next = SLOT_BITS'(TF_LEVEL3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      out_idx  <= '0;
      out_last <= '0;
    end else if (fire) begin
      out_full <= 1'b1;
      out_idx  <= '0;
      out_last <= last_next;
    end else if (out_done) begin
      out_full <= 1'b0;
    end else if (out_take) begin
      out_idx <= out_idx + SLOT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      slot_open[0]  <= in_open;
      slot_high[0]  <= in_high;
      slot_low[0]   <= in_low;
      slot_vol[0]   <= base_vol;
      slot_open[1]  <= b1_open;
      slot_high[1]  <= b1_high;
      slot_low[1]   <= b1_low;
      slot_vol[1]   <= b1_vol;
      slot_open[2]  <= b2_open;
      slot_high[2]  <= b2_high;
      slot_low[2]   <= b2_low;
      slot_vol[2]   <= b2_vol;
      slot_open[3]  <= b3_open;
      slot_high[3]  <= b3_high;
      slot_low[3]   <= b3_low;
      slot_vol[3]   <= b3_vol;
      res_close     <= in_close;
      res_day_high  <= day_high_next;
      res_day_low   <= day_low_next;
      win_high_old  <= local_high;
      win_low_old   <= local_low;
      win_high_new  <= win_latch ? pend_high_acc : local_high;
      win_low_new   <= win_latch ? pend_low_acc : local_low;
      total_old     <= volume_total;
      total_new     <= total_sat;
    end
  end

  // result port
  logic late_window;
  logic late_total;

  assign late_window = (out_idx == SLOT_BITS'(TF_LEVEL3));
  assign late_total  = (out_idx >= SLOT_BITS'(TF_LEVEL2));

  assign bar.valid          = out_full;
  assign bar.timeframe      = TF_BITS'(out_idx);
  assign bar.bar_open       = slot_open[out_idx];
  assign bar.bar_high       = slot_high[out_idx];
  assign bar.bar_low        = slot_low[out_idx];
  assign bar.bar_close      = res_close;
  assign bar.bar_volume     = slot_vol[out_idx];
  assign bar.day_high       = res_day_high;
  assign bar.day_low        = res_day_low;
  assign bar.window_high    = late_window ? win_high_new : win_high_old;
  assign bar.window_low     = late_window ? win_low_new : win_low_old;
  assign bar.running_volume = late_total ? total_new : total_old;
  assign bar.last_of_run    = (out_idx == out_last);

endmodule
